/* rtl/core/setpoint_profile_sequencer_macros.svh */
// Assertion macros for the setpoint profile sequencer.
`ifndef SETPOINT_PROFILE_SEQUENCER_MACROS_SVH
`define SETPOINT_PROFILE_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define SPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sps assertion failed");
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sps assertion failed");
`else
`define SPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/sps_pkg.sv */
`default_nettype none
package sps_pkg;

  localparam int STEP_W = 8;
  localparam int IN_SPEED_W = 16;
  localparam int IN_DUR_W = 32;
  localparam int STEP_INDEX_MAX = 255;

  localparam logic [2:0] ACT_WRITE  = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_START  = 3'd2;
  localparam logic [2:0] ACT_STOP   = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;
  localparam logic [2:0] ACT_REWIND = 3'd5;

  localparam logic [2:0] TASK_HOLD = 3'd0;
  localparam logic [2:0] TASK_RAMP = 3'd1;
  localparam logic [2:0] TASK_END  = 3'd2;
  localparam logic [2:0] TASK_NONE = 3'd3;

  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_FINISHED = 3'd2;
  localparam logic [2:0] ST_ILLEGAL  = 3'd3;
  localparam logic [2:0] ST_REFUSED  = 3'd4;

  typedef enum logic [1:0] {RD_CUR, RD_NEXT, RD_LAST} rd_sel_t;

  typedef struct packed {
    logic       cap;
    logic       wr;
    logic       start;
    logic       rewind;
    logic       tick;
    logic       rd;
    rd_sel_t    rd_sel;
    logic       adv;
    logic       halt;
    logic [2:0] halt_reason;
    logic       set_hold;
    logic       set_zero;
    logic       mul;
    logic       div_start;
    logic       set_ramp;
    logic       load_out;
    logic       out_acc;
    logic       out_ref;
  } sps_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       running;
    logic       len_zero;
    logic       write_ok;
    logic       append_ok;
    logic       ptr_ge_len;
    logic       next_ge_len;
    logic [2:0] rd_task;
    logic       el_gt_limit;
    logic       rd_dur_zero;
    logic       div_done;
    logic       out_free;
  } sps_stat_t;

endpackage
`default_nettype wire

/* rtl/core/sps_ram.sv */
`default_nettype none
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/core/sps_ctrl.sv */
`default_nettype none
module sps_ctrl
  import sps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sps_stat_t stat,
  output sps_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_START_CHK, S_EVAL, S_APPLY, S_DIVS, S_DIVW, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   acc_r, acc_nxt;
  logic   ref_r, ref_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    ref_nxt   = ref_r;
    cmd       = '0;
    cmd.out_acc = acc_r;
    cmd.out_ref = ref_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          acc_nxt   = 1'b0;
          ref_nxt   = 1'b0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        case (stat.action)
          ACT_WRITE: begin
            if (stat.write_ok) begin
              cmd.wr  = 1'b1;
              acc_nxt = 1'b1;
            end else begin
              ref_nxt = 1'b1;
            end
          end
          ACT_APPEND: begin
            if (stat.append_ok) begin
              cmd.wr  = 1'b1;
              acc_nxt = 1'b1;
            end else begin
              ref_nxt = 1'b1;
            end
          end
          ACT_START: begin
            if (stat.len_zero) begin
              ref_nxt = 1'b1;
            end else begin
              cmd.rd     = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_nxt  = S_START_CHK;
            end
          end
          ACT_STOP: begin
            cmd.halt        = 1'b1;
            cmd.halt_reason = ST_IDLE;
          end
          ACT_TICK: begin
            if (stat.running) begin
              cmd.tick = 1'b1;
              if (stat.ptr_ge_len) begin
                cmd.halt        = 1'b1;
                cmd.halt_reason = ST_ILLEGAL;
              end else begin
                cmd.rd     = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_nxt  = S_EVAL;
              end
            end
          end
          ACT_REWIND: cmd.rewind = 1'b1;
          default: ;
        endcase
      end
      S_START_CHK: begin
        if (stat.rd_task == TASK_END) begin
          cmd.start = 1'b1;
          acc_nxt   = 1'b1;
        end else begin
          ref_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_EVAL: begin
        state_nxt = S_APPLY;
        if (stat.el_gt_limit) begin
          cmd.adv = 1'b1;
          if (stat.next_ge_len) begin
            cmd.halt        = 1'b1;
            cmd.halt_reason = ST_ILLEGAL;
            state_nxt       = S_OUT;
          end else begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_NEXT;
          end
        end
      end
      S_APPLY: begin
        state_nxt = S_OUT;
        case (stat.rd_task)
          TASK_HOLD: cmd.set_hold = 1'b1;
          TASK_RAMP: begin
            if (stat.rd_dur_zero) begin
              cmd.set_hold = 1'b1;
            end else begin
              cmd.mul   = 1'b1;
              state_nxt = S_DIVS;
            end
          end
          TASK_END: begin
            cmd.set_zero    = 1'b1;
            cmd.halt        = 1'b1;
            cmd.halt_reason = ST_FINISHED;
          end
          TASK_NONE: ;
          default: begin
            cmd.halt        = 1'b1;
            cmd.halt_reason = ST_ILLEGAL;
          end
        endcase
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.set_ramp = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= 1'b0;
      ref_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      ref_r   <= ref_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sps_dp.sv */
`default_nettype none
module sps_dp
  import sps_pkg::*;
#(
  parameter int TABLE_DEPTH   = 256,
  parameter int SPEED_BITS    = 16,
  parameter int DURATION_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sps_cmd_t              cmd,
  output sps_stat_t                  stat,
  input  wire logic [2:0]            in_action,
  input  wire logic [STEP_W-1:0]     in_index,
  input  wire logic [2:0]            in_task,
  input  wire logic [IN_DUR_W-1:0]   in_duration,
  input  wire logic [IN_SPEED_W-1:0] in_speed,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IN_SPEED_W-1:0]      out_speed,
  output logic [2:0]                 out_status,
  output logic [STEP_W-1:0]          out_step,
  output logic                       out_motor,
  output logic                       out_acc
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int LIMIT   = (TABLE_DEPTH < STEP_INDEX_MAX) ? TABLE_DEPTH : STEP_INDEX_MAX;
  localparam int ENTRY_W = 3 + DURATION_BITS + SPEED_BITS;
  localparam int PW      = SPEED_BITS + DURATION_BITS;
  localparam int CW      = $clog2(PW + 1);

  logic [2:0]               act_r;
  logic [STEP_W-1:0]        idx_r;
  logic [2:0]               task_in_r;
  logic [DURATION_BITS-1:0] dur_in_r;
  logic [SPEED_BITS-1:0]    spd_in_r;

  logic [STEP_W-1:0]        len_r, ptr_r;
  logic [DURATION_BITS-1:0] el_r;
  logic [SPEED_BITS-1:0]    prev_r, setp_r;
  logic                     running_r, motor_r;
  logic [2:0]               reason_r;

  logic [PW-1:0]            prod_r, quo_r;
  logic                     neg_r;
  logic [DURATION_BITS:0]   rem_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r;

  logic                     ov_r;
  logic [IN_SPEED_W-1:0]    o_spd_r;
  logic [2:0]               o_st_r;
  logic [STEP_W-1:0]        o_step_r;
  logic                     o_mot_r, o_acc_r;

  logic                     we;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [ENTRY_W-1:0]       rdata;
  logic [2:0]               rd_task;
  logic [DURATION_BITS-1:0] rd_dur, limit;
  logic [SPEED_BITS-1:0]    rd_spd, mag, q;
  logic [SPEED_BITS:0]      diff;
  logic [DURATION_BITS:0]   shifted;
  logic                     fits;
  logic [STEP_W-1:0]        ptr_inc, len_dec;

  assign we      = cmd.wr;
  assign waddr   = (act_r == ACT_APPEND) ? len_r[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign ptr_inc = ptr_r + STEP_W'(1);
  assign len_dec = len_r - STEP_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_CUR:  raddr = ptr_r[IDX_W-1:0];
      RD_NEXT: raddr = ptr_inc[IDX_W-1:0];
      RD_LAST: raddr = len_dec[IDX_W-1:0];
      default: raddr = ptr_r[IDX_W-1:0];
    endcase
  end

  sps_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({task_in_r, dur_in_r, spd_in_r}),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_task = rdata[ENTRY_W-1 -: 3];
  assign rd_dur  = rdata[SPEED_BITS +: DURATION_BITS];
  assign rd_spd  = rdata[SPEED_BITS-1:0];
  assign limit   = (rd_task == TASK_NONE) ? '0 : rd_dur;
  assign diff    = {1'b0, rd_spd} - {1'b0, prev_r};
  assign mag     = diff[SPEED_BITS] ? SPEED_BITS'(-diff) : diff[SPEED_BITS-1:0];
  assign shifted = {rem_r[DURATION_BITS-1:0], quo_r[PW-1]};
  assign fits    = shifted >= {1'b0, rd_dur};
  assign q       = quo_r[SPEED_BITS-1:0];

  always_comb begin
    stat             = '0;
    stat.action      = act_r;
    stat.running     = running_r;
    stat.len_zero    = (len_r == '0);
    stat.write_ok    = (32'(idx_r) < LIMIT);
    stat.append_ok   = (32'(len_r) < LIMIT);
    stat.ptr_ge_len  = (ptr_r >= len_r);
    stat.next_ge_len = ({1'b0, ptr_r} + 9'd1) >= {1'b0, len_r};
    stat.rd_task     = rd_task;
    stat.el_gt_limit = (el_r > limit);
    stat.rd_dur_zero = (rd_dur == '0);
    stat.div_done    = !busy_r;
    stat.out_free    = !ov_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r     <= in_action;
      idx_r     <= in_index;
      task_in_r <= in_task;
      dur_in_r  <= DURATION_BITS'(in_duration);
      spd_in_r  <= SPEED_BITS'(in_speed);
    end
    if (cmd.mul) begin
      prod_r <= PW'(mag) * PW'(el_r);
      neg_r  <= diff[SPEED_BITS];
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= prod_r;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, rd_dur}) : shifted;
      quo_r <= {quo_r[PW-2:0], fits};
    end
    if (cmd.load_out) begin
      o_spd_r  <= IN_SPEED_W'(setp_r);
      o_st_r   <= cmd.out_ref ? ST_REFUSED : (running_r ? ST_RUNNING : reason_r);
      o_step_r <= ptr_r;
      o_mot_r  <= motor_r;
      o_acc_r  <= cmd.out_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ptr_r     <= '0;
      el_r      <= '0;
      prev_r    <= '0;
      setp_r    <= '0;
      running_r <= 1'b0;
      motor_r   <= 1'b0;
      reason_r  <= ST_IDLE;
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cmd.wr) begin
        if (act_r == ACT_APPEND) begin
          len_r <= len_r + STEP_W'(1);
        end else if (idx_r >= len_r) begin
          len_r <= idx_r + STEP_W'(1);
        end
      end
      if (cmd.start) begin
        running_r <= 1'b1;
        motor_r   <= 1'b1;
        el_r      <= '0;
      end
      if (cmd.tick && (el_r != '1)) begin
        el_r <= el_r + DURATION_BITS'(1);
      end
      if (cmd.adv) begin
        prev_r <= rd_spd;
        ptr_r  <= ptr_inc;
        el_r   <= '0;
      end
      if (cmd.halt) begin
        running_r <= 1'b0;
        motor_r   <= 1'b0;
        reason_r  <= cmd.halt_reason;
      end
      if (cmd.rewind) begin
        ptr_r    <= '0;
        el_r     <= '0;
        prev_r   <= '0;
        setp_r   <= '0;
        reason_r <= ST_IDLE;
      end
      if (cmd.set_hold) begin
        setp_r <= rd_spd;
      end else if (cmd.set_zero) begin
        setp_r <= '0;
      end else if (cmd.set_ramp) begin
        setp_r <= neg_r ? (prev_r - q) : (prev_r + q);
      end
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(PW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
      if (cmd.load_out) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid  = ov_r;
  assign out_speed  = o_spd_r;
  assign out_status = o_st_r;
  assign out_step   = o_step_r;
  assign out_motor  = o_mot_r;
  assign out_acc    = o_acc_r;

endmodule
`default_nettype wire

/* rtl/core/setpoint_profile_sequencer.sv */
// Channel | Dir | tdata (low bit up)                                   | tuser
// in_     | in  | step_index 8, step_task 3, step_duration 32,         | action 3
//         |     | step_speed 16, zero pad to 64                        |
// out_    | out | target_speed 16, status 3, current_step 8,           | -
//         |     | motor_on 1, accepted 1, zero pad to 32               |
// One beat in, one beat out. Write, append, stop and rewind are captured, decoded
// and loaded into the output register. Start also reads the last table entry, unless
// the table is empty. A tick while running evaluates the current entry and applies
// it, and a ramp step also runs the serial divider. A new beat is taken once the
// previous one is in the output register; a stalled output holds the following result until it drains.
// Synchronous active-low reset clears control state; the step table has no reset.
`default_nettype none
`include "setpoint_profile_sequencer_macros.svh"
module setpoint_profile_sequencer
  import sps_pkg::*;
#(
  parameter int TABLE_DEPTH   = 256,
  parameter int SPEED_BITS    = 16,
  parameter int DURATION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // step_index, step_task, step_duration, step_speed
  input  wire logic [2:0]  in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata  // target_speed, status, current_step, motor_on, accepted
);

  sps_cmd_t              cmd;
  sps_stat_t             stat;
  logic [IN_SPEED_W-1:0] o_speed;
  logic [2:0]            o_status;
  logic [STEP_W-1:0]     o_step;
  logic                  o_motor, o_acc;

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sps_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .SPEED_BITS    (SPEED_BITS),
    .DURATION_BITS (DURATION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_action   (in_tuser),
    .in_index    (in_tdata[7:0]),
    .in_task     (in_tdata[10:8]),
    .in_duration (in_tdata[42:11]),
    .in_speed    (in_tdata[58:43]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_speed   (o_speed),
    .out_status  (o_status),
    .out_step    (o_step),
    .out_motor   (o_motor),
    .out_acc     (o_acc)
  );

  assign out_tdata = {3'b000, o_acc, o_motor, o_step, o_status, o_speed};

  `SPS_ASSERT_SAME(a_motor_running, clk, rst_n, out_tvalid && (o_status != ST_REFUSED), (o_motor == (o_status == ST_RUNNING)))
  `SPS_ASSERT_SAME(a_acc_not_refused, clk, rst_n, out_tvalid && o_acc, o_status != ST_REFUSED)
  `SPS_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule
`default_nettype wire

/* tb/tb_setpoint_profile_sequencer.sv */
`timescale 1ns / 1ps
module tb_setpoint_profile_sequencer;
  import sps_pkg::*;

  localparam int STEP_CAP = 255;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  idx;
    logic [2:0]  task_code;
    logic [31:0] dur;
    logic [15:0] speed;
  } beat_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [2:0]  status;
    logic [7:0]  step;
    logic        motor;
    logic        acc;
  } setpoint_t;

  typedef struct {
    beat_t     b;
    logic      has_exp;
    setpoint_t exp_val;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [63:0] in_tdata;
  logic [2:0] in_tuser;
  logic [31:0] out_tdata;

  setpoint_profile_sequencer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),  // step_index, step_task, step_duration, step_speed
    .in_tuser(in_tuser),  // action
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)  // target_speed, status, current_step, motor_on, accepted
  );

  // profile state
  logic [2:0]  p_task [256];
  logic [31:0] p_dur [256];
  logic [15:0] p_speed [256];
  logic [8:0]  p_len;
  logic [7:0]  p_ptr;
  logic [31:0] p_elapsed;
  logic [15:0] p_prev, p_sp;
  logic        p_run, p_motor;
  logic [2:0]  p_reason;

  setpoint_t expected_setpoints[$];
  int errors = 0, mismatches = 0;
  int idle_cycles = 0;
  bit drained_input = 0;
  bit long_hold = 0;

  function automatic setpoint_t predict_setpoint(beat_t b);
    setpoint_t r;
    logic acc, refused;
    logic [7:0] p;
    logic [31:0] limit;
    logic [2:0] t;
    longint diff, q;
    acc = 0;
    refused = 0;
    case (b.action)
      ACT_WRITE: if (b.idx >= STEP_CAP) refused = 1; else begin
        p_task[b.idx] = b.task_code; p_dur[b.idx] = b.dur; p_speed[b.idx] = b.speed;
        if (b.idx >= p_len) p_len = 9'(b.idx) + 9'd1;
        acc = 1;
      end
      ACT_APPEND: if (p_len >= STEP_CAP) refused = 1; else begin
        p_task[p_len] = b.task_code; p_dur[p_len] = b.dur; p_speed[p_len] = b.speed;
        p_len++;
        acc = 1;
      end
      ACT_START: if (p_len == 0 || p_task[p_len - 1] != TASK_END) refused = 1; else begin
        p_run = 1; p_motor = 1; p_elapsed = 0; acc = 1;
      end
      ACT_STOP: begin
        p_run = 0; p_motor = 0; p_reason = ST_IDLE;
      end
      ACT_TICK: if (p_run) begin
        if (p_elapsed != 32'hffff_ffff) p_elapsed++;
        if (p_ptr >= p_len) begin
          p_run = 0; p_motor = 0; p_reason = ST_ILLEGAL;
        end else begin
          p = p_ptr;
          t = p_task[p];
          limit = (t == TASK_NONE) ? 0 : p_dur[p];
          if (p_elapsed > limit) begin
            p_prev = p_speed[p];
            p_ptr = p + 8'd1;
            p_elapsed = 0;
            p = p_ptr;
            t = p_task[p];
          end
          if ({1'b0, p_ptr} >= p_len) begin
            p_run = 0; p_motor = 0; p_reason = ST_ILLEGAL;
          end else begin
            case (t)
              TASK_HOLD: p_sp = p_speed[p];
              TASK_RAMP: if (p_dur[p] == 0) p_sp = p_speed[p]; else begin
                diff = longint'(p_speed[p]) - longint'(p_prev);
                q = (diff * longint'(p_elapsed)) / longint'(p_dur[p]);
                p_sp = 16'(longint'(p_prev) + q);
              end
              TASK_END: begin
                p_sp = 0; p_run = 0; p_motor = 0; p_reason = ST_FINISHED;
              end
              TASK_NONE: ;
              default: begin
                p_run = 0; p_motor = 0; p_reason = ST_ILLEGAL;
              end
            endcase
          end
        end
      end
      ACT_REWIND: begin
        p_ptr = 0; p_elapsed = 0; p_prev = 0; p_sp = 0; p_reason = ST_IDLE;
      end
      default: ;
    endcase
    r.speed = p_sp;
    r.status = refused ? ST_REFUSED : (p_run ? ST_RUNNING : p_reason);
    r.step = p_ptr;
    r.motor = p_motor;
    r.acc = acc;
    return r;
  endfunction

  function automatic beat_t mk(logic [2:0] a, logic [7:0] i, logic [2:0] t,
                               logic [31:0] d, logic [15:0] s);
    beat_t b;
    b.action = a; b.idx = i; b.task_code = t; b.dur = d; b.speed = s;
    return b;
  endfunction

  function automatic setpoint_t mkr(logic [15:0] s, logic [2:0] st, logic [7:0] p,
                                    logic m, logic a);
    setpoint_t r;
    r.speed = s; r.status = st; r.step = p; r.motor = m; r.acc = a;
    return r;
  endfunction

  // table is fully defined whenever the random stimulus may read it
  function automatic logic [31:0] rand_dur();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic send(beat_t b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'd0, b.speed, b.dur, b.task_code, b.idx};
    in_tuser <= b.action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_setpoints.push_back(predict_setpoint(b));
  endtask

  row_t rows[$];

  initial begin
    beat_t b;
    int n, len, k;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0; rst_n = 0;
    p_len = 0; p_ptr = 0; p_elapsed = 0; p_prev = 0; p_sp = 0;
    p_run = 0; p_motor = 0; p_reason = ST_IDLE;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    rows.push_back('{mk(ACT_START, 0, 0, 0, 0), 1, mkr(0, ST_REFUSED, 0, 0, 0)});
    rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0), 1, mkr(0, ST_IDLE, 0, 0, 0)});
    rows.push_back('{mk(ACT_WRITE, 255, 0, 0, 0), 1, mkr(0, ST_REFUSED, 0, 0, 0)});
    rows.push_back('{mk(ACT_APPEND, 0, TASK_HOLD, 1, 16'hffff), 1,
                     mkr(0, ST_IDLE, 0, 0, 1)});
    rows.push_back('{mk(ACT_START, 0, 0, 0, 0), 1, mkr(0, ST_REFUSED, 0, 0, 0)});
    rows.push_back('{mk(ACT_APPEND, 0, TASK_RAMP, 4, 16'h1000), 0, '0});
    rows.push_back('{mk(ACT_APPEND, 0, TASK_RAMP, 0, 16'h0200), 0, '0});
    rows.push_back('{mk(ACT_APPEND, 0, TASK_NONE, 32'hffff_ffff, 16'h0300), 0, '0});
    rows.push_back('{mk(ACT_APPEND, 0, TASK_END, 0, 0), 0, '0});
    rows.push_back('{mk(ACT_START, 0, 0, 0, 0), 1, mkr(0, ST_RUNNING, 0, 1, 1)});
    for (int i = 0; i < 11; i++) rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ACT_STOP, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ACT_REWIND, 0, 0, 0, 0), 1, mkr(0, ST_IDLE, 0, 0, 0)});
    rows.push_back('{mk(ACT_WRITE, 1, 3'd7, 32'hffff_ffff, 16'hffff), 1,
                     mkr(0, ST_IDLE, 0, 0, 1)});
    rows.push_back('{mk(3'd6, 8'hff, 0, 0, 0), 0, '0});
    foreach (rows[i]) begin
      send(rows[i].b);
      if (rows[i].has_exp && expected_setpoints[$] !== rows[i].exp_val) begin
        errors++;
        $display("directed row %0d: predictor %h table %h", i, expected_setpoints[$],
                 rows[i].exp_val);
      end
    end
    // random: build well-formed profiles, run them with ticks, some noise
    n = rows.size();
    while (n < 1200) begin
      send(mk(ACT_STOP, 0, 0, 0, 0));
      send(mk(ACT_REWIND, 0, 0, 0, 0));
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++)
        send(mk(ACT_WRITE, 8'(k), 3'($urandom_range(0, 12) == 0 ? $urandom_range(0, 7) :
                $urandom_range(0, 3)), rand_dur(), rand_speed()));
      send(mk(ACT_WRITE, 8'(len), TASK_END, $urandom, 16'($urandom)));
      n += len + 3;
      if ($urandom_range(0, 3) == 0) begin
        send(mk(ACT_APPEND, 0, 3'($urandom_range(0, 7)), rand_dur(), rand_speed()));
        n++;
      end
      send(mk(ACT_START, 0, 0, 0, 0));
      n++;
      k = $urandom_range(5, 30);
      repeat (k) begin
        case ($urandom_range(0, 19))
          0: b = mk(ACT_STOP, 0, 0, 0, 0);
          1: b = mk(ACT_START, 0, 0, 0, 0);
          2: b = mk(ACT_REWIND, 0, 0, 0, 0);
          3: b = mk(3'($urandom_range(6, 7)), 8'($urandom), 3'($urandom), $urandom,
                    16'($urandom));
          4: b = mk(ACT_WRITE, 8'($urandom_range(0, p_len > 0 ? p_len - 1 : 0)),
                    3'($urandom_range(0, 7)), rand_dur(), rand_speed());
          default: b = mk(ACT_TICK, 8'($urandom), 3'($urandom), $urandom, 16'($urandom));
        endcase
        send(b);
        n++;
      end
    end
    // fill the table to capacity, then try once more
    while (p_len < STEP_CAP) send(mk(ACT_APPEND, 0, TASK_END, $urandom, 16'($urandom)));
    send(mk(ACT_APPEND, 0, TASK_HOLD, 0, 0));
    send(mk(ACT_WRITE, 254, TASK_END, 0, 0));
    in_tvalid <= 0;
    drained_input = 1;
  end

  // receiver
  initial begin
    int gap;
    int got_n;
    got_n = 0;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold && got_n >= 200) begin
        long_hold = 1;
        out_tready <= 0;
        repeat (400) @(posedge clk);
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      repeat (gap) @(posedge clk);
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      out_tready <= 0;
      got_n++;
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    setpoint_t got, exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[18:16], out_tdata[26:19], out_tdata[27],
             out_tdata[28]};
      if (expected_setpoints.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected beat %h", out_tdata);
      end else begin
        exp_v = expected_setpoints.pop_front();
        if (got !== exp_v || out_tdata[31:29] !== 3'd0) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp spd %0d st %0d step %0d m %0b a %0b, got %h",
                     exp_v.speed, exp_v.status, exp_v.step, exp_v.motor, exp_v.acc,
                     out_tdata);
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (drained_input);
    fork
      begin
        wait (expected_setpoints.size() == 0);
        repeat (100) @(posedge clk);
      end
      wait (idle_cycles >= WATCHDOG_LIMIT);
    join_any
    if (expected_setpoints.size() != 0 || idle_cycles >= WATCHDOG_LIMIT) errors++;
    if (errors == 0)
      $display("[setpoint_profile_sequencer] OK");
    else
      $display("[setpoint_profile_sequencer] ERROR");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT && !drained_input);
    $display("[setpoint_profile_sequencer] ERROR");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/sps_pkg.sv
rtl/core/sps_ram.sv
rtl/core/sps_ctrl.sv
rtl/core/sps_dp.sv
rtl/core/setpoint_profile_sequencer.sv
tb/tb_setpoint_profile_sequencer.sv
